// ===== rtl/dlu_pkg.sv =====
// ----------------------------------------------------------------------------
// dlu_pkg
// Shared types and constants for the dense LU linear solver.
// ----------------------------------------------------------------------------
package dlu_pkg;

   localparam int FRAC_BITS = 24;
   localparam int IDX_BITS  = 4;
   localparam int DIM_BITS  = 5;

   localparam logic [1:0] REQ_LOAD_MAT = 2'd0;
   localparam logic [1:0] REQ_LOAD_RHS = 2'd1;
   localparam logic [1:0] REQ_SOLVE    = 2'd2;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_SINGULAR = 1'b1;

   typedef enum logic [1:0] {
      PH_COL,
      PH_ROW,
      PH_FWD,
      PH_BWD
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACC_RD,
      S_ACC_GET,
      S_A_RD,
      S_A_GET,
      S_B_GET,
      S_MAC_GO,
      S_MAC_WAIT,
      S_FIN,
      S_DIAG,
      S_DIV_GO,
      S_DIV_WAIT,
      S_OUT_RD,
      S_OUT_GET,
      S_OUT_WAIT,
      S_SING
   } solver_state_type;

   typedef enum logic {
      ARITH_MULSUB,
      ARITH_DIV
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_MSAT,
      A_MSUB,
      A_DIV,
      A_DSAT
   } arith_state_type;

endpackage

// ===== rtl/dlu_ram.sv =====
// ----------------------------------------------------------------------------
// dlu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlu_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dlu_arith.sv =====
// ----------------------------------------------------------------------------
// dlu_arith
// Shared bit-serial unit: saturating acc - a*b, and saturating acc / b.
// ----------------------------------------------------------------------------
module dlu_arith import dlu_pkg::*; #(
   parameter int VALUE_BITS = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  arith_cmd_type                cmd,
   input  logic signed [VALUE_BITS-1:0] acc,
   input  logic signed [VALUE_BITS-1:0] a,
   input  logic signed [VALUE_BITS-1:0] b,
   output logic                         done,
   output logic signed [VALUE_BITS-1:0] result
);

   localparam int VB = VALUE_BITS;
   localparam int PW = 2 * VB;
   localparam int DW = VB + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam logic [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
   localparam logic [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

   arith_state_type state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            neg_ff, neg_in;
   logic [VB-1:0]   mcand_ff, mcand_in;
   logic [PW-1:0]   prod_ff, prod_in;
   logic [VB-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [VB-1:0]   acc_ff, acc_in;
   logic [VB-1:0]   mul_ff, mul_in;
   logic [VB-1:0]   result_ff, result_in;
   logic            done_ff, done_in;

   logic [VB-1:0] acc_mag, a_mag, b_mag;
   logic [VB:0]   mul_sum;
   logic [PW-1:0] prod_shr;
   logic [VB:0]   div_shift;
   logic [VB+1:0] div_diff;
   logic          div_ge;
   logic [VB:0]   sub_diff;

   function automatic logic [VB-1:0] sat_mag(input logic neg, input logic big,
                                             input logic [VB-1:0] low);
      logic [VB-1:0] res;
      if (neg) begin
         res = big ? VMIN : (~low + 1'b1);
      end else begin
         res = big ? VMAX : low;
      end
      return res;
   endfunction

   assign acc_mag = acc[VB-1] ? (~acc + 1'b1) : acc;
   assign a_mag   = a[VB-1] ? (~a + 1'b1) : a;
   assign b_mag   = b[VB-1] ? (~b + 1'b1) : b;

   assign mul_sum   = {1'b0, prod_ff[PW-1:VB]} + {1'b0, mcand_ff};
   assign prod_shr  = prod_ff >> FRAC_BITS;
   assign div_shift = {rem_ff, quo_ff[DW-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, mcand_ff};
   assign div_ge    = ~div_diff[VB+1];
   assign sub_diff  = {acc_ff[VB-1], acc_ff} - {mul_ff[VB-1], mul_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               state_in = (cmd.op == ARITH_DIV) ? A_DIV : A_MUL;
            end
         end
         A_MUL:  if (cnt_ff == CW'(VB - 1)) state_in = A_MSAT;
         A_MSAT: state_in = A_MSUB;
         A_MSUB: state_in = A_IDLE;
         A_DIV:  if (cnt_ff == CW'(DW - 1)) state_in = A_DSAT;
         A_DSAT: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff + 1'b1;
      neg_in    = neg_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      acc_in    = acc_ff;
      mul_in    = mul_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         A_IDLE: begin
            cnt_in = '0;
            if (cmd.start) begin
               if (cmd.op == ARITH_DIV) begin
                  neg_in   = acc[VB-1] ^ b[VB-1];
                  mcand_in = b_mag;
                  rem_in   = '0;
                  quo_in   = {acc_mag, {FRAC_BITS{1'b0}}};
               end else begin
                  neg_in   = a[VB-1] ^ b[VB-1];
                  mcand_in = a_mag;
                  prod_in  = {{VB{1'b0}}, b_mag};
                  acc_in   = acc;
               end
            end
         end
         A_MUL: begin
            prod_in = prod_ff[0] ? {mul_sum, prod_ff[VB-1:1]} : {1'b0, prod_ff[PW-1:1]};
         end
         A_MSAT: begin
            mul_in = sat_mag(neg_ff, |prod_shr[PW-1:VB-1], prod_shr[VB-1:0]);
         end
         A_MSUB: begin
            if (sub_diff[VB] != sub_diff[VB-1]) begin
               result_in = sub_diff[VB] ? VMIN : VMAX;
            end else begin
               result_in = sub_diff[VB-1:0];
            end
            done_in = 1'b1;
         end
         A_DIV: begin
            rem_in = div_ge ? div_diff[VB-1:0] : div_shift[VB-1:0];
            quo_in = {quo_ff[DW-2:0], div_ge};
         end
         A_DSAT: begin
            result_in = sat_mag(neg_ff, |quo_ff[DW-1:VB-1], quo_ff[VB-1:0]);
            done_in   = 1'b1;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      acc_ff    <= acc_in;
      mul_ff    <= mul_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== rtl/dense_lu_linear_solver.sv =====
// Load items: one transfer per cycle while idle, straight into the matrix or rhs RAM.
// Solve: factorization and substitution run on the one bit-serial multiply/divide unit;
//   results then leave one at a time in index order, holding while stalled. No new item
//   is taken until the last result.
// Reset (synchronous, active high) clears control state and sets dim to 1; the RAMs
//   are not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
// dense_lu_linear_solver
// Crout LU factorization in place, then forward and back substitution.
// ----------------------------------------------------------------------------
module dense_lu_linear_solver import dlu_pkg::*; #(
   parameter int MAX_N      = 16,
   parameter int VALUE_BITS = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [IDX_BITS-1:0]          req_row,
   input  logic [IDX_BITS-1:0]          req_col,
   input  logic signed [VALUE_BITS-1:0] req_value,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [IDX_BITS-1:0]          rsp_index,
   output logic signed [VALUE_BITS-1:0] rsp_solution,
   output logic                         rsp_last,
   output logic                         rsp_status,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [DIM_BITS-1:0]          csr_dim
);

   localparam int VB     = VALUE_BITS;
   localparam int IW     = $clog2(MAX_N);
   localparam int AW     = 2 * IW;
   localparam int MDEPTH = 1 << AW;
   localparam int VDEPTH = 1 << IW;

   // --- registers ---
   solver_state_type state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [DIM_BITS-1:0] dim_ff;
   logic [IW-1:0]    nm1_ff, nm1_in;      // n - 1
   logic [IW-1:0]    p_ff, p_in;          // pivot step
   logic [IW-1:0]    i_ff, i_in;          // element (column/row/vector) index
   logic [IW-1:0]    k_ff, k_in;          // inner dot-product index
   logic [VB-1:0]    acc_ff, acc_in;
   logic [VB-1:0]    a_ff, a_in;
   logic [VB-1:0]    b_ff, b_in;
   logic [VB-1:0]    piv_ff, piv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [VB-1:0]    rsp_sol_ff, rsp_sol_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_status_ff, rsp_status_in;

   // --- memory ports ---
   logic          m_we, r_we, w_we;
   logic [AW-1:0] m_waddr, m_raddr;
   logic [IW-1:0] r_waddr, r_raddr, w_waddr, w_raddr;
   logic [VB-1:0] m_wdata, r_wdata, w_wdata;
   logic [VB-1:0] m_rdata, r_rdata, w_rdata;

   // --- shared arithmetic unit ---
   arith_cmd_type arith_cmd;
   logic          arith_done;
   logic [VB-1:0] arith_result;

   // --- decode helpers ---
   logic                req_xfer;
   logic                row_ok, col_ok;
   logic [IW-1:0]       req_row_i, req_col_i;
   logic [DIM_BITS-1:0] dim_eff;
   logic [IW-1:0]       nm1_solve;
   logic [IW-1:0]       row_sel, col_sel;
   logic                is_factor, inner_empty, k_last, i_last, piv_zero;
   logic [IW:0]         k_lim;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign req_row_i = IW'(req_row);
   assign req_col_i = IW'(req_col);
   assign row_ok    = (32'(req_row) < 32'(MAX_N));
   assign col_ok    = (32'(req_col) < 32'(MAX_N));

   // dim 0 acts as 1, dim above MAX_N as MAX_N
   assign dim_eff   = (dim_ff == '0) ? DIM_BITS'(1) : dim_ff;
   assign nm1_solve = (32'(dim_eff) > 32'(MAX_N)) ? IW'(MAX_N - 1)
                                                 : IW'(dim_eff - 1'b1);

   // Both Crout passes read a = M[row][k], b = M[k][col] around target M[row][col]
   assign row_sel   = (phase_ff == PH_ROW) ? p_ff : i_ff;
   assign col_sel   = (phase_ff == PH_COL) ? p_ff : i_ff;
   assign is_factor = (phase_ff == PH_COL) || (phase_ff == PH_ROW);
   assign i_last    = (i_ff == nm1_ff);

   always_comb begin
      case (phase_ff)
         PH_FWD:  inner_empty = (i_ff == '0);
         PH_BWD:  inner_empty = i_last;
         default: inner_empty = (p_ff == '0);
      endcase
   end

   assign k_lim  = (phase_ff == PH_FWD) ? {1'b0, i_ff} : {1'b0, p_ff};
   assign k_last = (phase_ff == PH_BWD) ? (k_ff == nm1_ff)
                                        : (({1'b0, k_ff} + 1'b1) == k_lim);

   // pivot of this step is complete once the diagonal element is written back
   assign piv_zero = ((i_ff == p_ff) ? acc_ff : piv_ff) == '0;

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_xfer && req_type == REQ_SOLVE) state_in = S_ACC_RD;
         S_ACC_RD:   state_in = S_ACC_GET;
         S_ACC_GET:  state_in = inner_empty ? S_FIN : S_A_RD;
         S_A_RD:     state_in = S_A_GET;
         S_A_GET:    state_in = S_B_GET;
         S_B_GET:    state_in = S_MAC_GO;
         S_MAC_GO:   state_in = S_MAC_WAIT;
         S_MAC_WAIT: if (arith_done) state_in = k_last ? S_FIN : S_A_RD;
         S_FIN: begin
            unique case (phase_ff)
               PH_COL:  state_in = (i_last && piv_zero) ? S_SING : S_ACC_RD;
               PH_ROW:  state_in = S_DIV_GO;
               PH_FWD:  state_in = S_DIAG;
               PH_BWD:  state_in = (i_ff == '0) ? S_OUT_RD : S_ACC_RD;
               default: state_in = S_IDLE;
            endcase
         end
         S_DIAG:     state_in = S_DIV_GO;
         S_DIV_GO:   state_in = S_DIV_WAIT;
         S_DIV_WAIT: if (arith_done) state_in = S_ACC_RD;
         S_OUT_RD:   state_in = S_OUT_GET;
         S_OUT_GET:  state_in = S_OUT_WAIT;
         S_OUT_WAIT: if (!rsp_stall) state_in = rsp_last_ff ? S_IDLE : S_OUT_RD;
         S_SING:     state_in = S_OUT_WAIT;
         default:    state_in = S_IDLE;
      endcase
   end

   // --- datapath and memory control ---
   always_comb begin
      phase_in      = phase_ff;
      nm1_in        = nm1_ff;
      p_in          = p_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      piv_in        = piv_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_sol_in    = rsp_sol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      m_we    = 1'b0;
      m_waddr = {row_sel, col_sel};
      m_wdata = acc_ff;
      m_raddr = {row_sel, col_sel};
      r_we    = 1'b0;
      r_waddr = req_row_i;
      r_wdata = req_value;
      r_raddr = i_ff;
      w_we    = 1'b0;
      w_waddr = i_ff;
      w_wdata = acc_ff;
      w_raddr = i_ff;

      arith_cmd.start = 1'b0;
      arith_cmd.op    = ARITH_MULSUB;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_type)
                  REQ_LOAD_MAT: begin
                     m_we    = row_ok && col_ok;
                     m_waddr = {req_row_i, req_col_i};
                     m_wdata = req_value;
                  end
                  REQ_LOAD_RHS: begin
                     r_we = row_ok;
                  end
                  REQ_SOLVE: begin
                     nm1_in   = nm1_solve;
                     p_in     = '0;
                     i_in     = '0;
                     phase_in = PH_COL;
                  end
                  default: begin
                     r_we = 1'b0;
                  end
               endcase
            end
         end
         S_ACC_GET: begin
            case (phase_ff)
               PH_FWD:  acc_in = r_rdata;
               PH_BWD:  acc_in = w_rdata;
               default: acc_in = m_rdata;
            endcase
            k_in = (phase_ff == PH_BWD) ? IW'(i_ff + 1'b1) : '0;
         end
         S_A_RD: begin
            m_raddr = {row_sel, k_ff};
         end
         S_A_GET: begin
            a_in    = m_rdata;
            m_raddr = {k_ff, col_sel};
            w_raddr = k_ff;
         end
         S_B_GET: begin
            b_in = is_factor ? m_rdata : w_rdata;
         end
         S_MAC_GO: begin
            arith_cmd.start = 1'b1;
            arith_cmd.op    = ARITH_MULSUB;
         end
         S_MAC_WAIT: begin
            if (arith_done) begin
               acc_in = arith_result;
               k_in   = k_ff + 1'b1;
            end
         end
         S_FIN: begin
            unique case (phase_ff)
               PH_COL: begin
                  m_we = 1'b1;
                  if (i_ff == p_ff) begin
                     piv_in = acc_ff;
                  end
                  if (!i_last) begin
                     i_in = i_ff + 1'b1;
                  end else if (p_ff == nm1_ff) begin
                     phase_in = PH_FWD;
                     i_in     = '0;
                  end else begin
                     phase_in = PH_ROW;
                     i_in     = p_ff + 1'b1;
                  end
               end
               PH_ROW: begin
                  b_in = piv_ff;
               end
               PH_FWD: begin
                  m_raddr = {i_ff, i_ff};
               end
               PH_BWD: begin
                  w_we = 1'b1;
                  if (i_ff == '0) begin
                     k_in = '0;
                  end else begin
                     i_in = i_ff - 1'b1;
                  end
               end
               default: begin
                  m_we = 1'b0;
               end
            endcase
         end
         S_DIAG: begin
            b_in = m_rdata;
         end
         S_DIV_GO: begin
            arith_cmd.start = 1'b1;
            arith_cmd.op    = ARITH_DIV;
         end
         S_DIV_WAIT: begin
            if (arith_done) begin
               if (phase_ff == PH_ROW) begin
                  m_we    = 1'b1;
                  m_wdata = arith_result;
                  if (i_last) begin
                     p_in     = p_ff + 1'b1;
                     i_in     = p_ff + 1'b1;
                     phase_in = PH_COL;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  w_we    = 1'b1;
                  w_wdata = arith_result;
                  if (i_last) begin
                     phase_in = PH_BWD;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end
            end
         end
         S_OUT_RD: begin
            w_raddr = k_ff;
         end
         S_OUT_GET: begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = IDX_BITS'(k_ff);
            rsp_sol_in    = w_rdata;
            rsp_last_in   = (k_ff == nm1_ff);
            rsp_status_in = STATUS_OK;
         end
         S_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               k_in         = k_ff + 1'b1;
            end
         end
         S_SING: begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = '0;
            rsp_sol_in    = '0;
            rsp_last_in   = 1'b1;
            rsp_status_in = STATUS_SINGULAR;
         end
         default: begin
            m_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dim_ff       <= DIM_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            dim_ff <= csr_dim;
         end
      end
      phase_ff      <= phase_in;
      nm1_ff        <= nm1_in;
      p_ff          <= p_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      piv_ff        <= piv_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sol_ff    <= rsp_sol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_solution = rsp_sol_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;

   // --- instances ---
   dlu_ram #(.WIDTH(VB), .DEPTH(MDEPTH)) u_matrix (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   dlu_ram #(.WIDTH(VB), .DEPTH(VDEPTH)) u_rhs (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   dlu_ram #(.WIDTH(VB), .DEPTH(VDEPTH)) u_work (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   dlu_arith #(.VALUE_BITS(VB)) u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .acc    (acc_ff),
      .a      (a_ff),
      .b      (b_ff),
      .done   (arith_done),
      .result (arith_result)
   );

endmodule

// ===== rtl/dlu_checker.sv =====
// ----------------------------------------------------------------------------
// dlu_checker
// Port-level checks for the dense LU linear solver.
// ----------------------------------------------------------------------------
module dlu_checker import dlu_pkg::*; #(
   parameter int VALUE_BITS = 48
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [IDX_BITS-1:0]          rsp_index,
   input logic signed [VALUE_BITS-1:0] rsp_solution,
   input logic                         rsp_last,
   input logic                         rsp_status
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_solution) && $stable(rsp_index))
      else $error("stalled result changed");

   // a singular solve gives one zero result at index 0 that ends the solve
   a_singular: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && rsp_index == '0 && rsp_solution == '0)
      else $error("malformed singular result");

   // no new request while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // each transfer is followed by a gap cycle
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("back-to-back results");

endmodule

bind dense_lu_linear_solver dlu_checker #(.VALUE_BITS(VALUE_BITS)) u_dlu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_index    (rsp_index),
   .rsp_solution (rsp_solution),
   .rsp_last     (rsp_last),
   .rsp_status   (rsp_status)
);
